// ----- src/prime_factorizer_top_assert.svh -----
// Assertion macros used by the prime factorizer top level.
`ifndef PRIME_FACTORIZER_TOP_ASSERT_SVH
`define PRIME_FACTORIZER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/pf_pkg.sv -----
// Shared constants, control-word types and the microcode table of the prime factorizer.
package pf_pkg;

  // Field widths and limits
  localparam int VALUE_BITS_DEF = 32;
  localparam int FACTOR_BITS    = 31;
  localparam int MAX_RESULTS    = 30;
  localparam int K_BITS         = $clog2(MAX_RESULTS);
  localparam int FIRST_DIVISOR  = 2;
  localparam int SECOND_DIVISOR = 3;
  localparam int ODD_STEP       = 2;

  // Quotient bits resolved by the divider per cycle
  localparam int DIV_STEP_BITS  = 4;

  // Microprogram addresses
  localparam int PC_BITS = 4;
  localparam logic [PC_BITS-1:0] PC_IDLE   = 4'd0;
  localparam logic [PC_BITS-1:0] PC_DIVGO  = 4'd1;
  localparam logic [PC_BITS-1:0] PC_TEST   = 4'd2;
  localparam logic [PC_BITS-1:0] PC_CHECK  = 4'd3;
  localparam logic [PC_BITS-1:0] PC_FULL   = 4'd4;
  localparam logic [PC_BITS-1:0] PC_EMITF  = 4'd5;
  localparam logic [PC_BITS-1:0] PC_NONE   = 4'd6;
  localparam logic [PC_BITS-1:0] PC_FINAL  = 4'd7;
  localparam logic [PC_BITS-1:0] PC_NEXTD  = 4'd8;

  // Wait selects: the step holds until its condition is met
  localparam logic [1:0] WAIT_NONE = 2'd0;
  localparam logic [1:0] WAIT_IN   = 2'd1;
  localparam logic [1:0] WAIT_DIV  = 2'd2;
  localparam logic [1:0] WAIT_OUT  = 2'd3;

  // Datapath actions
  localparam logic [2:0] ACT_NONE        = 3'd0;
  localparam logic [2:0] ACT_LOAD        = 3'd1;
  localparam logic [2:0] ACT_DIVGO       = 3'd2;
  localparam logic [2:0] ACT_EMIT_FACTOR = 3'd3;
  localparam logic [2:0] ACT_EMIT_NONE   = 3'd4;
  localparam logic [2:0] ACT_EMIT_REM    = 3'd5;
  localparam logic [2:0] ACT_NEXT_D      = 3'd6;

  // Jump conditions
  localparam logic [2:0] COND_NEVER  = 3'd0;
  localparam logic [2:0] COND_ALWAYS = 3'd1;
  localparam logic [2:0] COND_SMALL  = 3'd2;
  localparam logic [2:0] COND_D_GT_Q = 3'd3;
  localparam logic [2:0] COND_R_NZ   = 3'd4;
  localparam logic [2:0] COND_K_FULL = 3'd5;

  typedef struct packed {
    logic [1:0]         wait_sel;
    logic [2:0]         act;
    logic [2:0]         cond;
    logic [PC_BITS-1:0] target;
  } uword_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic slot_free;
    logic div_done;
    logic small_val;
    logic d_gt_q;
    logic r_nz;
    logic k_full;
  } stat_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic       fire;
    logic       in_ready;
    logic [2:0] act;
  } ctrl_t;

  // Microcode table: one control word per step
  function automatic uword_t pf_rom(input logic [PC_BITS-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_IDLE:  w = '{WAIT_IN,   ACT_LOAD,        COND_SMALL,  PC_NONE};
      PC_DIVGO: w = '{WAIT_NONE, ACT_DIVGO,       COND_NEVER,  PC_IDLE};
      PC_TEST:  w = '{WAIT_DIV,  ACT_NONE,        COND_D_GT_Q, PC_FINAL};
      PC_CHECK: w = '{WAIT_NONE, ACT_NONE,        COND_R_NZ,   PC_NEXTD};
      PC_FULL:  w = '{WAIT_NONE, ACT_NONE,        COND_K_FULL, PC_FINAL};
      PC_EMITF: w = '{WAIT_OUT,  ACT_EMIT_FACTOR, COND_ALWAYS, PC_DIVGO};
      PC_NONE:  w = '{WAIT_OUT,  ACT_EMIT_NONE,   COND_ALWAYS, PC_IDLE};
      PC_FINAL: w = '{WAIT_OUT,  ACT_EMIT_REM,    COND_ALWAYS, PC_IDLE};
      PC_NEXTD: w = '{WAIT_NONE, ACT_NEXT_D,      COND_ALWAYS, PC_DIVGO};
      default:  w = '{WAIT_NONE, ACT_NONE,        COND_ALWAYS, PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- src/pf_divider.sv -----
// Multi-cycle restoring divider giving quotient and remainder, several bits per cycle.
module pf_divider import pf_pkg::*; #(
  parameter int WIDTH = VALUE_BITS_DEF - 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int ITER     = (WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int PADW     = ITER * DIV_STEP_BITS;
  localparam int CNT_BITS = $clog2(ITER + 1);

  logic [WIDTH:0]        part_r, part_nxt;
  logic [PADW-1:0]       quo_r, quo_nxt;
  logic [WIDTH-1:0]      dvs_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  busy_r;
  logic                  done_r;

  // Resolve DIV_STEP_BITS quotient bits: shift in, compare, subtract
  always_comb begin
    part_nxt = part_r;
    quo_nxt  = quo_r;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      part_nxt = {part_nxt[WIDTH-1:0], quo_nxt[PADW-1]};
      quo_nxt  = {quo_nxt[PADW-2:0], 1'b0};
      if (part_nxt >= {1'b0, dvs_r}) begin
        part_nxt   = part_nxt - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
    end
  end

  // Operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      part_r <= '0;
      quo_r  <= PADW'(dividend);
      dvs_r  <= divisor;
    end else if (busy_r) begin
      part_r <= part_nxt;
      quo_r  <= quo_nxt;
    end
  end

  // Iteration count and handshake flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_BITS'(ITER);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r[WIDTH-1:0];
  assign remainder = part_r[WIDTH-1:0];

endmodule

// ----- src/pf_sequencer.sv -----
// Microcode sequencer: step counter, control table lookup, waits and conditional jumps.
module pf_sequencer import pf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [PC_BITS-1:0] pc_r, pc_nxt;
  uword_t             word;
  logic               stall;
  logic               jump;

  assign word = pf_rom(pc_r);

  // Hold the step until what it waits for is there
  always_comb begin
    unique case (word.wait_sel)
      WAIT_IN:   stall = !stat.in_valid;
      WAIT_DIV:  stall = !stat.div_done;
      WAIT_OUT:  stall = !stat.slot_free;
      default:   stall = 1'b0;
    endcase
  end

  // Evaluate the jump condition
  always_comb begin
    unique case (word.cond)
      COND_ALWAYS: jump = 1'b1;
      COND_SMALL:  jump = stat.small_val;
      COND_D_GT_Q: jump = stat.d_gt_q;
      COND_R_NZ:   jump = stat.r_nz;
      COND_K_FULL: jump = stat.k_full;
      default:     jump = 1'b0;
    endcase
  end

  // Advance, jump or hold
  always_comb begin
    if (stall) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = word.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.fire     = !stall;
  assign ctrl.in_ready = (word.wait_sel == WAIT_IN);
  assign ctrl.act      = word.act;

endmodule

// ----- src/prime_factorizer_top.sv -----
// Prime factorizer top level: factoring datapath, result register and sequencer wiring.
//
// Takes one signed value per request and returns its prime factors in ascending order,
// with repeats, one result request per factor, the last one flagged by out_last; a value
// of 1 or less gives a single result with out_none set and factor 0. One value is worked
// at a time and in_ready is high only while the sequencer waits for a request. Each trial
// divisor (2, then the odd numbers) costs one pass through the shared divider plus the
// sequencer steps around it; the divider resolves four quotient bits per cycle. The
// number of trials is set by the square root of the cofactor that remains, so a 32-bit
// prime near 2^31 takes about 23171 trials; small values and values with small factors
// need far fewer trials. Each emitted factor adds one step, and can hold while out_ready
// is low.
module prime_factorizer_top import pf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_BITS-1:0]  in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [FACTOR_BITS-1:0] out_factor,
  output logic                   out_last,
  output logic                   out_none
);

  localparam int W     = VALUE_BITS - 1;
  localparam int EXT_W = (W > FACTOR_BITS) ? W : FACTOR_BITS;

  stat_t stat;
  ctrl_t ctrl;

  logic [W-1:0]           rem_r;
  logic [W-1:0]           div_r;
  logic [K_BITS-1:0]      k_r;
  logic                   out_valid_r;
  logic [FACTOR_BITS-1:0] factor_r;
  logic                   last_r;
  logic                   none_r;

  logic                   div_start;
  logic                   div_done;
  logic [W-1:0]           quotient;
  logic [W-1:0]           remainder;
  logic [W-1:0]           div_next;
  logic [EXT_W-1:0]       d_ext;
  logic [EXT_W-1:0]       rem_ext;
  logic                   emit;

  pf_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  pf_divider #(
    .WIDTH (W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rem_r),
    .divisor   (div_r),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // Status back to the sequencer
  assign stat.in_valid  = in_valid;
  assign stat.slot_free = !out_valid_r || out_ready;
  assign stat.div_done  = div_done;
  assign stat.small_val = in_value[VALUE_BITS-1] || (in_value[W-1:1] == '0);
  assign stat.d_gt_q    = (div_r > quotient);
  assign stat.r_nz      = (remainder != '0);
  assign stat.k_full    = (k_r == K_BITS'(MAX_RESULTS - 1));

  assign div_start = ctrl.fire && (ctrl.act == ACT_DIVGO);
  assign emit      = ctrl.fire && ((ctrl.act == ACT_EMIT_FACTOR) ||
                                   (ctrl.act == ACT_EMIT_NONE) ||
                                   (ctrl.act == ACT_EMIT_REM));

  // Step to 3 after 2, then over odd divisors only
  assign div_next = (div_r == W'(FIRST_DIVISOR)) ? W'(SECOND_DIVISOR) : div_r + W'(ODD_STEP);

  // Factors wider than the result field are masked
  assign d_ext   = EXT_W'(div_r);
  assign rem_ext = EXT_W'(rem_r);

  // Remainder, trial divisor and result count
  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      unique case (ctrl.act)
        ACT_LOAD: begin
          rem_r <= in_value[W-1:0];
          div_r <= W'(FIRST_DIVISOR);
          k_r   <= '0;
        end
        ACT_EMIT_FACTOR: begin
          rem_r <= quotient;
          k_r   <= k_r + 1'b1;
        end
        ACT_NEXT_D: begin
          div_r <= div_next;
        end
        default: begin
        end
      endcase
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (emit) begin
      unique case (ctrl.act)
        ACT_EMIT_FACTOR: begin
          factor_r <= d_ext[FACTOR_BITS-1:0];
          last_r   <= 1'b0;
          none_r   <= 1'b0;
        end
        ACT_EMIT_NONE: begin
          factor_r <= '0;
          last_r   <= 1'b1;
          none_r   <= 1'b1;
        end
        default: begin
          factor_r <= rem_ext[FACTOR_BITS-1:0];
          last_r   <= 1'b1;
          none_r   <= 1'b0;
        end
      endcase
    end
  end

  // Result valid: set on emit, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_ready   = ctrl.in_ready;
  assign out_valid  = out_valid_r;
  assign out_factor = factor_r;
  assign out_last   = last_r;
  assign out_none   = none_r;

`include "prime_factorizer_top_assert.svh"

  `PF_ASSERT_IMP(a_idle_div_quiet, in_ready, div_done || !div_start, "request taken while divider started")
  `PF_ASSERT_IMP(a_none_shape, out_valid && out_none, out_last && (out_factor == '0), "malformed none result")
  `PF_ASSERT_IMP(a_divgo_operands, div_start, (div_r >= W'(FIRST_DIVISOR)) && (rem_r >= W'(FIRST_DIVISOR)), "divider started on bad operands")
  `PF_ASSERT_NXT(a_emit_sets_valid, emit, out_valid, "emitted result not presented")

endmodule

// ----- tb/prime_factorizer_top_tb.sv -----
// Self-checking testbench for the prime factorizer: directed table, then random values.
module prime_factorizer_top_tb import pf_pkg::*; ();

  localparam int  VBITS       = VALUE_BITS_DEF;
  localparam int  N_DIRECTED  = 19;
  localparam int  N_RANDOM    = 81;
  localparam int  WIDE_IDX    = 50;
  localparam int  MAX_REPORTS = 10;
  localparam longint CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [FACTOR_BITS-1:0] factor;
    logic                   last;
    logic                   none;
  } factor_res_t;

  typedef struct packed {
    logic [VBITS-1:0]       value;
    logic                   typed;
    logic [FACTOR_BITS-1:0] factor;
    logic                   last;
    logic                   none;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [VBITS-1:0]       in_value;
  logic                   out_valid;
  logic                   out_ready;
  logic [FACTOR_BITS-1:0] out_factor;
  logic                   out_last;
  logic                   out_none;

  factor_res_t expected_factors[$];
  int          mismatch_count;
  int          results_seen;
  int          values_sent;
  longint      cycle_count;
  logic        tx_burst;
  logic        rx_burst;

  prime_factorizer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_factor (out_factor),
    .out_last   (out_last),
    .out_none   (out_none)
  );

  // Free-running clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Queue one expected result behind the others
  function automatic void expect_res(input logic [FACTOR_BITS-1:0] f, input logic l,
                                     input logic n);
    factor_res_t r;
    r = '{f, l, n};
    expected_factors.insert(expected_factors.size(), r);
  endfunction

  // Trial division of one value; queues its results in emission order
  function automatic void predict_factors(input logic [VBITS-1:0] v);
    longint unsigned rem;
    longint unsigned div;
    int              k;
    factor_res_t     r;
    if (v[VBITS-1] || v <= 1) begin
      expect_res('0, 1'b1, 1'b1);
      return;
    end
    rem = v;
    div = FIRST_DIVISOR;
    k   = 0;
    while (div <= rem / div) begin
      if (rem % div == 0) begin
        // out of result slots: the cofactor closes the run
        if (k == MAX_RESULTS - 1) begin
          expect_res(FACTOR_BITS'(rem), 1'b1, 1'b0);
          return;
        end
        expect_res(FACTOR_BITS'(div), 1'b0, 1'b0);
        k++;
        rem = rem / div;
      end else begin
        div++;
      end
    end
    if (rem > 1) begin
      expect_res(FACTOR_BITS'(rem), 1'b1, 1'b0);
    end else if (k > 0) begin
      r = expected_factors.pop_back();
      expect_res(r.factor, 1'b1, r.none);
    end
  endfunction

  // Directed table: typed results only where they are obvious
  function automatic dir_row_t dir_row(input int idx);
    dir_row_t r;
    r = '0;
    unique case (idx)
      0:  r = '{32'd0,          1'b1, 31'd0,          1'b1, 1'b1};
      1:  r = '{32'd1,          1'b1, 31'd0,          1'b1, 1'b1};
      2:  r = '{32'hFFFF_FFFF,  1'b1, 31'd0,          1'b1, 1'b1};
      3:  r = '{32'h8000_0000,  1'b1, 31'd0,          1'b1, 1'b1};
      4:  r = '{32'hFFFF_FFFE,  1'b1, 31'd0,          1'b1, 1'b1};
      5:  r = '{32'd2,          1'b1, 31'd2,          1'b1, 1'b0};
      6:  r = '{32'd3,          1'b1, 31'd3,          1'b1, 1'b0};
      7:  r = '{32'h7FFF_FFFF,  1'b1, 31'h7FFF_FFFF,  1'b1, 1'b0};
      8:  r = '{32'd4,          1'b0, 31'd0,          1'b0, 1'b0};
      9:  r = '{32'd9,          1'b0, 31'd0,          1'b0, 1'b0};
      10: r = '{32'd12,         1'b0, 31'd0,          1'b0, 1'b0};
      11: r = '{32'd63001,      1'b0, 31'd0,          1'b0, 1'b0};
      12: r = '{32'd912673,     1'b0, 31'd0,          1'b0, 1'b0};
      13: r = '{32'h4000_0000,  1'b0, 31'd0,          1'b0, 1'b0};
      14: r = '{32'h6000_0000,  1'b0, 31'd0,          1'b0, 1'b0};
      15: r = '{32'd2147483646, 1'b0, 31'd0,          1'b0, 1'b0};
      16: r = '{32'd30030,      1'b0, 31'd0,          1'b0, 1'b0};
      17: r = '{32'd131042,     1'b0, 31'd0,          1'b0, 1'b0};
      default: r = '{32'h5555_5555, 1'b0, 31'd0,      1'b0, 1'b0};
    endcase
    return r;
  endfunction

  // Mostly small cofactors shifted across the word, some values with no factors,
  // and one wide value that runs the divider for a long time
  function automatic logic [VBITS-1:0] random_value(input int idx);
    int               b;
    int               s;
    logic [VBITS-1:0] m;
    if (idx == WIDE_IDX) return {2'b01, 30'($urandom)};
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 3) == 0) return VBITS'($urandom_range(0, 1));
      return $urandom | 32'h8000_0000;
    end
    b = $urandom_range(2, 16);
    m = ($urandom & ((32'd1 << b) - 1)) | 32'd2;
    s = $urandom_range(0, 31 - b);
    return m << s;
  endfunction

  // Offer one request after a gap; entered and left at a falling edge
  task automatic send_value(input logic [VBITS-1:0] v, input int gap,
                            input dir_row_t row, input logic use_row);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    if (use_row && row.typed) begin
      expect_res(row.factor, row.last, row.none);
    end else begin
      predict_factors(v);
    end
    values_sent++;
    @(negedge clk);
  endtask

  function automatic int draw_gap(input logic burst);
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  // Result side: stall at random, with stretches of no stalls
  initial begin
    int stall;
    out_ready = 1'b0;
    rx_burst  = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
      stall = draw_gap(rx_burst);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Compare each result request with the oldest expectation
  always @(posedge clk) begin
    factor_res_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_factors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("ERROR: unexpected result factor=%0d last=%0b none=%0b",
                   out_factor, out_last, out_none);
      end else begin
        exp_r = expected_factors.pop_front();
        if (out_factor !== exp_r.factor || out_last !== exp_r.last ||
            out_none !== exp_r.none) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: result %0d: expected factor=%0d last=%0b none=%0b, got factor=%0d last=%0b none=%0b",
                     results_seen, exp_r.factor, exp_r.last, exp_r.none,
                     out_factor, out_last, out_none);
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_factors.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random values, drain
  initial begin
    dir_row_t row;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_value       = '0;
    mismatch_count = 0;
    results_seen   = 0;
    values_sent    = 0;
    cycle_count    = 0;
    tx_burst       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = dir_row(i);
      send_value(row.value, draw_gap(tx_burst), row, 1'b1);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 15) == 0) tx_burst = ~tx_burst;
      send_value(random_value(i), draw_gap(tx_burst), '0, 1'b0);
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (expected_factors.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    mismatch_count += expected_factors.size();
    $display("Factored %0d values (%0d from the directed table), checked %0d results in %0d cycles.",
             values_sent, N_DIRECTED, results_seen, cycle_count);
    $display("Mismatches: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/pf_pkg.sv
src/pf_divider.sv
src/pf_sequencer.sv
src/prime_factorizer_top.sv
tb/prime_factorizer_top_tb.sv
